// File: sv/srp_pkg.sv
// Shared types and constants for the slash record parser.
package srp_pkg;

  localparam logic [7:0] SLASH_CH    = 8'h2F;
  localparam logic [7:0] EVENT_ON_CH = 8'h31;
  localparam logic [7:0] ZERO_CH     = 8'h30;
  localparam logic [7:0] NINE_CH     = 8'h39;
  localparam logic [7:0] PLUS_CH     = 8'h2B;
  localparam logic [7:0] MINUS_CH    = 8'h2D;
  localparam logic [7:0] SPACE_CH    = 8'h20;
  localparam logic [7:0] TAB_CH      = 8'h09;
  localparam logic [7:0] CR_CH       = 8'h0D;

  localparam int NUMBER_W = 16;
  localparam int TIME_W   = 32;

  // Bits of the completed-field mask.
  localparam int DONE_NUMBER_BIT = 0;
  localparam int DONE_EVENT_BIT  = 1;
  localparam int DONE_TIME_BIT   = 2;
  localparam logic [2:0] DONE_ALL = 3'b111;

  typedef enum logic [1:0] {
    FLD_NAME   = 2'd0,
    FLD_NUMBER = 2'd1,
    FLD_EVENT  = 2'd2,
    FLD_TIME   = 2'd3
  } field_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  localparam logic KIND_ECHO    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         name_byte;
    logic [7:0]         name_length;
    logic signed [15:0] number_value;
    logic               event_flag;
    logic [31:0]        time_value;
    logic               parse_ok;
  } result_t;

endpackage

// File: sv/srp_if.sv
// Valid/ready channel interfaces for record bytes and parse results.
interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_record;

  modport source(output valid, ch, end_of_record, input ready);
  modport sink(input valid, ch, end_of_record, output ready);
endinterface

interface srp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         name_byte;
  logic [7:0]         name_length;
  logic signed [15:0] number_value;
  logic               event_flag;
  logic [31:0]        time_value;
  logic               parse_ok;

  modport source(output valid, kind, name_byte, name_length, number_value, event_flag,
                 time_value, parse_ok, input ready);
  modport sink(input valid, kind, name_byte, name_length, number_value, event_flag,
               time_value, parse_ok, output ready);
endinterface

// File: sv/srp_atoi_step.sv
// One byte step of the whitespace, sign and decimal digit reader.
module srp_atoi_step #(
  parameter int W = srp_pkg::NUMBER_W
) (
  input  logic [7:0]      c,
  input  srp_pkg::phase_t phase,
  input  logic            neg,
  input  logic [W-1:0]    acc,
  output srp_pkg::phase_t phase_next,
  output logic            neg_next,
  output logic [W-1:0]    acc_next
);

  logic         is_digit;
  logic         is_space;
  logic [3:0]   digit_val;
  logic [W-1:0] digit_ext;
  logic [W-1:0] acc_x10;

  assign is_digit  = (c >= srp_pkg::ZERO_CH) && (c <= srp_pkg::NINE_CH);
  assign is_space  = (c == srp_pkg::SPACE_CH) ||
                     ((c >= srp_pkg::TAB_CH) && (c <= srp_pkg::CR_CH));
  assign digit_val = 4'(c - srp_pkg::ZERO_CH);
  assign digit_ext = W'(digit_val);
  // Times ten as two shifts and an add; wraps at W bits.
  assign acc_x10   = (acc << 3) + (acc << 1);

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    unique case (phase)
      srp_pkg::PH_START: begin
        if (is_space) begin
          phase_next = srp_pkg::PH_START;
        end else if ((c == srp_pkg::PLUS_CH) || (c == srp_pkg::MINUS_CH)) begin
          neg_next   = (c == srp_pkg::MINUS_CH);
          phase_next = srp_pkg::PH_DIGITS;
        end else if (is_digit) begin
          acc_next   = digit_ext;
          phase_next = srp_pkg::PH_DIGITS;
        end else begin
          phase_next = srp_pkg::PH_STOP;
        end
      end
      srp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          acc_next = acc_x10 + digit_ext;
        end else begin
          phase_next = srp_pkg::PH_STOP;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

endmodule

// File: sv/srp_parse_core.sv
// Record parse state, field commit logic and result formation for one byte.
module srp_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  input  logic             eor,
  output logic             has_result,
  output srp_pkg::result_t result
);

  localparam int NW = srp_pkg::NUMBER_W;
  localparam int TW = srp_pkg::TIME_W;

  srp_pkg::field_t field_pos, field_pos_next;
  logic [7:0]      name_count, name_count_next;
  logic            field_nonempty, field_nonempty_next;
  logic [2:0]      field_done_mask, field_done_mask_next;
  srp_pkg::phase_t number_phase, number_phase_next;
  logic            number_negative, number_negative_next;
  logic [NW-1:0]   number_accum, number_accum_next;
  srp_pkg::phase_t time_phase, time_phase_next;
  logic            time_negative, time_negative_next;
  logic [TW-1:0]   time_accum, time_accum_next;
  logic [7:0]      last_event_byte, last_event_byte_next;
  logic [NW-1:0]   stored_number, stored_number_next;
  logic            stored_event, stored_event_next;
  logic [TW-1:0]   stored_time, stored_time_next;

  srp_pkg::phase_t num_ph_step, time_ph_step;
  logic            num_neg_step, time_neg_step;
  logic [NW-1:0]   num_acc_step;
  logic [TW-1:0]   time_acc_step;

  logic          slash_adv;
  logic          commit_now;
  logic [NW-1:0] number_c;
  logic          event_c;
  logic [TW-1:0] time_c;
  logic [2:0]    mask_c;
  logic [7:0]    name_count_inc;

  srp_atoi_step #(.W(NW)) u_number_step (
    .c(ch), .phase(number_phase), .neg(number_negative), .acc(number_accum),
    .phase_next(num_ph_step), .neg_next(num_neg_step), .acc_next(num_acc_step)
  );

  srp_atoi_step #(.W(TW)) u_time_step (
    .c(ch), .phase(time_phase), .neg(time_negative), .acc(time_accum),
    .phase_next(time_ph_step), .neg_next(time_neg_step), .acc_next(time_acc_step)
  );

  assign slash_adv      = !eor && (ch == srp_pkg::SLASH_CH) && (field_pos != srp_pkg::FLD_TIME);
  assign commit_now     = eor || slash_adv;
  assign name_count_inc = (name_count != 8'hFF) ? name_count + 8'd1 : name_count;

  // Values as they stand after committing the open field, if it holds any byte.
  always_comb begin
    number_c = stored_number;
    event_c  = stored_event;
    time_c   = stored_time;
    mask_c   = field_done_mask;
    if (commit_now && field_nonempty) begin
      case (field_pos)
        srp_pkg::FLD_NUMBER: begin
          number_c = number_negative ? (NW'(0) - number_accum) : number_accum;
          mask_c[srp_pkg::DONE_NUMBER_BIT] = 1'b1;
        end
        srp_pkg::FLD_EVENT: begin
          event_c = (last_event_byte == srp_pkg::EVENT_ON_CH);
          mask_c[srp_pkg::DONE_EVENT_BIT] = 1'b1;
        end
        srp_pkg::FLD_TIME: begin
          time_c = time_negative ? (TW'(0) - time_accum) : time_accum;
          mask_c[srp_pkg::DONE_TIME_BIT] = 1'b1;
        end
        default: begin
          mask_c = field_done_mask;
        end
      endcase
    end
  end

  always_comb begin
    field_pos_next       = field_pos;
    name_count_next      = name_count;
    field_nonempty_next  = field_nonempty;
    field_done_mask_next = mask_c;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_accum_next    = number_accum;
    time_phase_next      = time_phase;
    time_negative_next   = time_negative;
    time_accum_next      = time_accum;
    last_event_byte_next = last_event_byte;
    stored_number_next   = number_c;
    stored_event_next    = event_c;
    stored_time_next     = time_c;

    has_result          = 1'b0;
    result.kind         = srp_pkg::KIND_ECHO;
    result.name_byte    = ch;
    result.name_length  = name_count_inc;
    result.number_value = stored_number;
    result.event_flag   = stored_event;
    result.time_value   = stored_time;
    result.parse_ok     = 1'b0;

    if (commit_now) begin
      field_nonempty_next  = 1'b0;
      number_phase_next    = srp_pkg::PH_START;
      number_negative_next = 1'b0;
      number_accum_next    = '0;
      time_phase_next      = srp_pkg::PH_START;
      time_negative_next   = 1'b0;
      time_accum_next      = '0;
      last_event_byte_next = '0;
    end

    if (eor) begin
      has_result           = 1'b1;
      result.kind          = srp_pkg::KIND_SUMMARY;
      result.name_byte     = '0;
      result.name_length   = name_count;
      result.number_value  = number_c;
      result.event_flag    = event_c;
      result.time_value    = time_c;
      result.parse_ok      = (mask_c == srp_pkg::DONE_ALL);
      field_pos_next       = srp_pkg::FLD_NAME;
      name_count_next      = '0;
      field_done_mask_next = '0;
    end else if (slash_adv) begin
      field_pos_next = srp_pkg::field_t'(field_pos + 2'd1);
    end else begin
      field_nonempty_next = 1'b1;
      case (field_pos)
        srp_pkg::FLD_NAME: begin
          has_result      = 1'b1;
          name_count_next = name_count_inc;
        end
        srp_pkg::FLD_NUMBER: begin
          number_phase_next    = num_ph_step;
          number_negative_next = num_neg_step;
          number_accum_next    = num_acc_step;
        end
        srp_pkg::FLD_EVENT: begin
          last_event_byte_next = ch;
        end
        default: begin
          time_phase_next    = time_ph_step;
          time_negative_next = time_neg_step;
          time_accum_next    = time_acc_step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_pos       <= srp_pkg::FLD_NAME;
      name_count      <= '0;
      field_nonempty  <= 1'b0;
      field_done_mask <= '0;
      number_phase    <= srp_pkg::PH_START;
      number_negative <= 1'b0;
      number_accum    <= '0;
      time_phase      <= srp_pkg::PH_START;
      time_negative   <= 1'b0;
      time_accum      <= '0;
      last_event_byte <= '0;
      stored_number   <= '0;
      stored_event    <= 1'b0;
      stored_time     <= '0;
    end else if (step) begin
      field_pos       <= field_pos_next;
      name_count      <= name_count_next;
      field_nonempty  <= field_nonempty_next;
      field_done_mask <= field_done_mask_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_accum    <= number_accum_next;
      time_phase      <= time_phase_next;
      time_negative   <= time_negative_next;
      time_accum      <= time_accum_next;
      last_event_byte <= last_event_byte_next;
      stored_number   <= stored_number_next;
      stored_event    <= stored_event_next;
      stored_time     <= stored_time_next;
    end
  end

endmodule

// File: sv/slash_record_parser_unit.sv
// Top level of the slash record parser: input register, parse core, result register.
//
//   Channel   Direction  Carries
//   rec_in    sink       ch, end_of_record: one record byte or the end-of-record mark
//   res_out   source     the seven result fields: a name echo or a record summary
//
// A new transaction on rec_in can be accepted every cycle unless a byte waits on a stalled res_out.
// A result reaches res_out through the input register and then the result register; the
// multiply-by-ten-and-add of the 32-bit time field through the parse logic sets the path length.
// Reset (rst, synchronous) clears both stage valid bits and all parse state and stored values.
// When res_out stalls, the result register holds; a byte that produces no result still
// moves through, and a byte that needs the held result register waits in the input register.
module slash_record_parser_unit (
  input  logic      clk,
  input  logic      rst,
  srp_in_if.sink    rec_in,
  srp_out_if.source res_out
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_eor;

  // Result register.
  logic             out_valid;
  srp_pkg::result_t out_data;

  logic             core_has_result;
  srp_pkg::result_t core_result;
  logic             out_free;
  logic             s1_fire;
  logic             in_take;

  // The result register can take a new result when empty or being drained this cycle.
  assign out_free = !out_valid || res_out.ready;
  // The held byte is processed unless it needs the result register and that is blocked.
  assign s1_fire  = s1_valid && (!core_has_result || out_free);
  assign rec_in.ready = !s1_valid || s1_fire;
  assign in_take  = rec_in.valid && rec_in.ready;

  srp_parse_core u_core (
    .clk(clk),
    .rst(rst),
    .step(s1_fire),
    .ch(s1_ch),
    .eor(s1_eor),
    .has_result(core_has_result),
    .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch  <= rec_in.ch;
      s1_eor <= rec_in.end_of_record;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && core_has_result) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && core_has_result) begin
      out_data <= core_result;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.kind         = out_data.kind;
  assign res_out.name_byte    = out_data.name_byte;
  assign res_out.name_length  = out_data.name_length;
  assign res_out.number_value = out_data.number_value;
  assign res_out.event_flag   = out_data.event_flag;
  assign res_out.time_value   = out_data.time_value;
  assign res_out.parse_ok     = out_data.parse_ok;

  // A byte held in the input register keeps its contents until it is processed.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_ch) && $stable(s1_eor))
    else $error("input register changed while its byte was waiting");

  // A name echo always counts at least its own byte and never reports success.
  a_echo_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == srp_pkg::KIND_ECHO)
      |-> (out_data.name_length != 8'd0) && !out_data.parse_ok)
    else $error("name echo with zero length or parse_ok set");

  // A summary carries no name byte.
  a_summary_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == srp_pkg::KIND_SUMMARY) |-> (out_data.name_byte == 8'd0))
    else $error("summary with a nonzero name byte");

  // A new result is loaded only when the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_fire && core_has_result |-> !out_valid || res_out.ready)
    else $error("result register overwritten while holding an untaken result");

endmodule
